// File: sv/aeo_pkg.sv
// ----------------------------------------------------------------------------
// aeo_pkg
// Shared types and constants for the arc-eager oracle unit: channel payloads,
// action codes, sequencer states and the command/status bundles between parts.
// ----------------------------------------------------------------------------
package aeo_pkg;

  localparam int MAX_TOKENS_DEF = 32;
  localparam int TOK_W          = 5;
  localparam int HEAD_W         = 6;
  localparam int LABEL_W        = 8;

  typedef enum logic [1:0] {
    ACT_SHIFT  = 2'd0,
    ACT_REDUCE = 2'd1,
    ACT_LEFT   = 2'd2,
    ACT_RIGHT  = 2'd3
  } action_t;

  typedef struct packed {
    logic signed [HEAD_W-1:0] gold_head;
    logic [LABEL_W-1:0]       gold_label;
    logic                     is_last;
  } tok_item_t;

  typedef struct packed {
    action_t            action;
    logic [LABEL_W-1:0] arc_label;
    logic               end_of_run;
  } act_item_t;

  typedef struct packed {
    logic      valid;
    act_item_t item;
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_TOPW,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [TOK_W-1:0] wdata;
  } stack_cmd_t;

  typedef struct packed {
    logic               info_we;
    logic [TOK_W-1:0]   info_addr;
    logic [HEAD_W-1:0]  info_gold;
    logic [LABEL_W-1:0] info_label;
    logic               head_we;
    logic [TOK_W-1:0]   head_addr;
    logic [TOK_W-1:0]   head_data;
    logic               clear_heads;
    logic [TOK_W-1:0]   raddr;
  } tok_cmd_t;

  typedef struct packed {
    logic               head_valid;
    logic [TOK_W-1:0]   head;
    logic [HEAD_W-1:0]  gold;
    logic [LABEL_W-1:0] label;
  } tok_rd_t;

endpackage

// File: sv/aeo_stack.sv
// ----------------------------------------------------------------------------
// aeo_stack
// Token stack: a synchronous memory with a size counter. The entry below the
// size counter is read every cycle and shows up on top in the next cycle.
// ----------------------------------------------------------------------------
module aeo_stack import aeo_pkg::*; #(
  parameter int  MAX_TOKENS = MAX_TOKENS_DEF,
  localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
  localparam int SP_W       = $clog2(MAX_TOKENS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  stack_cmd_t       cmd,
  output logic [SP_W-1:0]  sp,
  output logic [TOK_W-1:0] top
);

  logic [IDX_W-1:0] mem [MAX_TOKENS];
  logic [IDX_W-1:0] top_q;
  logic [SP_W-1:0]  sp_dec;
  logic [IDX_W-1:0] rd_addr;

  assign sp_dec  = sp - SP_W'(1);
  assign rd_addr = (sp == '0) ? '0 : sp_dec[IDX_W-1:0];
  assign top     = TOK_W'(top_q);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[sp[IDX_W-1:0]] <= cmd.wdata[IDX_W-1:0];
    end
    top_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.clear) begin
      sp <= '0;
    end else if (cmd.push) begin
      sp <= sp + SP_W'(1);
    end else if (cmd.pop) begin
      sp <= sp_dec;
    end
  end

endmodule

// File: sv/aeo_tok_store.sv
// ----------------------------------------------------------------------------
// aeo_tok_store
// Per-token store: gold head and label memory, assigned head memory with a
// valid bit per token. Both memories share one read address; their data is
// registered and appears in the next cycle.
// ----------------------------------------------------------------------------
module aeo_tok_store import aeo_pkg::*; #(
  parameter int  MAX_TOKENS = MAX_TOKENS_DEF,
  localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1
) (
  input  logic     clk,
  input  logic     rst,
  input  tok_cmd_t cmd,
  output tok_rd_t  rd
);

  logic [HEAD_W+LABEL_W-1:0] info [MAX_TOKENS];
  logic [IDX_W-1:0]          heads [MAX_TOKENS];
  logic [MAX_TOKENS-1:0]     head_vld;
  logic [HEAD_W+LABEL_W-1:0] info_q;
  logic [IDX_W-1:0]          head_q;
  logic                      vld_q;
  logic [IDX_W-1:0]          raddr;

  assign raddr = cmd.raddr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.info_we) begin
      info[cmd.info_addr[IDX_W-1:0]] <= {cmd.info_gold, cmd.info_label};
    end
    if (cmd.head_we) begin
      heads[cmd.head_addr[IDX_W-1:0]] <= cmd.head_data[IDX_W-1:0];
    end
    info_q <= info[raddr];
    head_q <= heads[raddr];
  end

  // clear all heads at sentence start
  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
      vld_q    <= 1'b0;
    end else begin
      if (cmd.clear_heads) begin
        head_vld <= '0;
      end else if (cmd.head_we) begin
        head_vld[cmd.head_addr[IDX_W-1:0]] <= 1'b1;
      end
      vld_q <= head_vld[raddr];
    end
  end

  assign rd.head_valid = vld_q;
  assign rd.head       = TOK_W'(head_q);
  assign rd.gold       = info_q[HEAD_W+LABEL_W-1:LABEL_W];
  assign rd.label      = info_q[LABEL_W-1:0];

endmodule

// File: sv/aeo_seq.sv
// ----------------------------------------------------------------------------
// aeo_seq
// Oracle sequencer: takes one token, reads the stack top, walks its head
// chain through the token store and emits one action per decision; after
// the last token of a sentence it drains the stack with reduces.
module aeo_seq import aeo_pkg::*; #(
  parameter int  MAX_TOKENS = MAX_TOKENS_DEF,
  localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
  localparam int SP_W       = $clog2(MAX_TOKENS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_stall,
  input  tok_item_t        tok,
  input  logic             can_emit,
  output emit_t            emit,
  output stack_cmd_t       scmd,
  output tok_cmd_t         tcmd,
  input  logic [SP_W-1:0]  sp,
  input  logic [TOK_W-1:0] stop,
  input  tok_rd_t          rd
);

  state_t             state, state_next;
  logic [IDX_W-1:0]   ntok, ntok_next;
  logic [IDX_W-1:0]   beta;
  logic               g_root;
  logic [TOK_W-1:0]   g_val;
  logic [LABEL_W-1:0] cur_label;
  logic               last;
  logic [TOK_W-1:0]   s;
  logic [TOK_W-1:0]   t, t_next;
  logic               accept;
  logic               done;
  logic [TOK_W-1:0]   beta_t;
  logic               chain_hit;

  assign beta_t    = TOK_W'(beta);
  assign chain_hit = !rd.gold[HEAD_W-1] && (rd.gold[TOK_W-1:0] == beta_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ntok  <= '0;
    end else begin
      state <= state_next;
      ntok  <= ntok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beta      <= ntok;
      g_root    <= tok.gold_head[HEAD_W-1];
      g_val     <= tok.gold_head[TOK_W-1:0];
      cur_label <= tok.gold_label;
      last      <= tok.is_last || (ntok == IDX_W'(MAX_TOKENS - 1));
    end
    if (state == ST_TOPW) begin
      s <= stop;
    end
    t <= t_next;
  end

  always_comb begin
    state_next = state;
    ntok_next  = ntok;
    t_next     = t;
    emit       = '0;
    scmd       = '0;
    tcmd       = '0;
    tcmd.raddr = t;
    tok_stall  = (state != ST_IDLE);
    accept     = 1'b0;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (tok_valid) begin
          accept           = 1'b1;
          scmd.clear       = (ntok == '0);
          tcmd.clear_heads = (ntok == '0);
          tcmd.info_we     = 1'b1;
          tcmd.info_addr   = TOK_W'(ntok);
          tcmd.info_gold   = tok.gold_head;
          tcmd.info_label  = tok.gold_label;
          state_next       = ST_TOP;
        end
      end
      ST_TOP: begin
        if (sp == '0) begin
          if (can_emit) begin
            emit.valid       = 1'b1;
            emit.item.action = ACT_SHIFT;
            scmd.push        = 1'b1;
            scmd.wdata       = beta_t;
            done             = 1'b1;
          end
        end else begin
          state_next = ST_TOPW;
        end
      end
      ST_TOPW: begin
        tcmd.raddr = stop;
        t_next     = stop;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (rd.head_valid) begin
          // advance one link down the chain
          tcmd.raddr = rd.head;
          t_next     = rd.head;
        end else if (can_emit) begin
          emit.valid = 1'b1;
          if (chain_hit) begin
            scmd.pop   = 1'b1;
            state_next = ST_TOP;
            if (t == s) begin
              emit.item.action    = ACT_LEFT;
              emit.item.arc_label = rd.label;
              tcmd.head_we        = 1'b1;
              tcmd.head_addr      = t;
              tcmd.head_data      = beta_t;
            end else begin
              emit.item.action = ACT_REDUCE;
            end
          end else if (g_root || (g_val > beta_t)) begin
            emit.item.action = ACT_SHIFT;
            scmd.push        = 1'b1;
            scmd.wdata       = beta_t;
            done             = 1'b1;
          end else if (g_val == s) begin
            emit.item.action    = ACT_RIGHT;
            emit.item.arc_label = cur_label;
            tcmd.head_we        = 1'b1;
            tcmd.head_addr      = beta_t;
            tcmd.head_data      = s;
            scmd.push           = 1'b1;
            scmd.wdata          = beta_t;
            done                = 1'b1;
          end else begin
            emit.item.action = ACT_REDUCE;
            scmd.pop         = 1'b1;
            state_next       = ST_TOP;
          end
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit.valid           = 1'b1;
          emit.item.action     = ACT_REDUCE;
          emit.item.end_of_run = (sp == SP_W'(1));
          scmd.pop             = 1'b1;
          if (sp == SP_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // token placed on the stack: close it out or drain the sentence
    if (done) begin
      emit.item.end_of_run = !last;
      ntok_next            = last ? '0 : beta + IDX_W'(1);
      state_next           = last ? ST_FLUSH : ST_IDLE;
    end
  end

endmodule

// File: sv/arc_eager_oracle_unit.sv
// ----------------------------------------------------------------------------
// arc_eager_oracle_unit
// Streaming arc-eager static oracle: tokens in, parser actions out.
// ----------------------------------------------------------------------------
// Input channel tok: one transaction per token (gold head, label, last flag).
// Output channel act: one transaction per action; end_of_run marks the last
// action a token causes. A token is taken only while the previous one is
// fully decided, so tokens go through one at a time.
// Per token: the sequencer accepts it, then for each action shifts at once
// when the stack is empty, otherwise reads the stack top (ST_TOP, then ST_TOPW)
// and walks the head chain in ST_WALK, one registered token-store read per
// link, before it decides. Trailing reduces after the last token come from
// ST_FLUSH. The first action goes into the output register from ST_TOP when
// the stack is empty, otherwise after the stack-top read and the chain walk.
// A one-entry output register holds the current action; while it is full and
// act_stall is high the sequencer holds its next action, and the next token is
// accepted as soon as the final action of a token sits in that register.
// Reset clears the stack, the token counter and all assigned heads; a new
// sentence also clears them when its first token is accepted.
// ----------------------------------------------------------------------------
module arc_eager_oracle_unit import aeo_pkg::*; #(
  parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      tok_valid,
  output logic      tok_stall,
  input  tok_item_t tok,
  output logic      act_valid,
  input  logic      act_stall,
  output act_item_t act
);

  localparam int SP_W = $clog2(MAX_TOKENS + 1);

  emit_t            emit;
  stack_cmd_t       scmd;
  tok_cmd_t         tcmd;
  tok_rd_t          rd;
  logic [SP_W-1:0]  sp;
  logic [TOK_W-1:0] stop;
  logic             can_emit;

  assign can_emit = !act_valid || !act_stall;

  aeo_stack #(.MAX_TOKENS(MAX_TOKENS)) u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (scmd),
    .sp  (sp),
    .top (stop)
  );

  aeo_tok_store #(.MAX_TOKENS(MAX_TOKENS)) u_store (
    .clk (clk),
    .rst (rst),
    .cmd (tcmd),
    .rd  (rd)
  );

  aeo_seq #(.MAX_TOKENS(MAX_TOKENS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok),
    .can_emit  (can_emit),
    .emit      (emit),
    .scmd      (scmd),
    .tcmd      (tcmd),
    .sp        (sp),
    .stop      (stop),
    .rd        (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
    end else if (emit.valid) begin
      act_valid <= 1'b1;
    end else if (!act_stall) begin
      act_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      act <= emit.item;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_stall |=> tok_stall)
    else $error("token accepted while previous token still in flight");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    emit.valid && (emit.item.action == ACT_REDUCE || emit.item.action == ACT_LEFT)
      |-> sp != '0)
    else $error("pop action issued on an empty stack");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    emit.valid && (emit.item.action == ACT_SHIFT || emit.item.action == ACT_RIGHT)
      |=> sp == $past(sp) + SP_W'(1))
    else $error("shift or right-arc did not push the token");

  a_idle_after_end: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.item.end_of_run |=> !tok_stall)
    else $error("sequencer not ready after final action of a token");

endmodule

// File: verif/arc_eager_oracle_unit_test.sv
// ----------------------------------------------------------------------------
// arc_eager_oracle_unit_test
// Self-checking bench for the streaming arc-eager oracle. A fixed table of
// short sentences and an overlong chain come first. Random sentences follow:
// closed, open and overlong sentences with nearby heads, and raw noise tokens.
// Each output action is checked field by field against the table entry or a
// local oracle model. Both channels idle at random, and the action side holds
// off once for a long stretch so the unit backs up and stalls its token input.
// ----------------------------------------------------------------------------
module arc_eager_oracle_unit_test;
  import aeo_pkg::*;

  localparam int MAXT      = MAX_TOKENS_DEF;
  localparam int NO_HEAD   = -1;
  localparam int RAND_TOKS = 360;
  localparam int IDLE_PCT  = 21;

  typedef struct packed {
    tok_item_t item;
    logic      known;
    act_item_t want;
  } script_row_t;

  localparam int SCRIPT_LEN = 24;

  // gold_head 6'h3F is -1 (root), 6'h20 is -32
  script_row_t script_rows [SCRIPT_LEN] = '{
    '{'{6'h3F, 8'h00, 1'b0}, 1'b1, '{ACT_SHIFT, 8'h00, 1'b1}},
    '{'{6'h00, 8'hFF, 1'b0}, 1'b1, '{ACT_RIGHT, 8'hFF, 1'b1}},
    '{'{6'h01, 8'h5A, 1'b0}, 1'b1, '{ACT_RIGHT, 8'h5A, 1'b1}},
    '{'{6'h04, 8'h33, 1'b0}, 1'b1, '{ACT_SHIFT, 8'h00, 1'b1}},
    '{'{6'h02, 8'hA5, 1'b0}, 1'b0, '0},
    '{'{6'h20, 8'h01, 1'b0}, 1'b1, '{ACT_SHIFT, 8'h00, 1'b1}},
    '{'{6'h1F, 8'h80, 1'b1}, 1'b0, '0},
    '{'{6'h01, 8'h11, 1'b0}, 1'b1, '{ACT_SHIFT, 8'h00, 1'b1}},
    '{'{6'h3F, 8'h22, 1'b0}, 1'b0, '0},
    '{'{6'h01, 8'h44, 1'b1}, 1'b0, '0},
    '{'{6'h00, 8'h0F, 1'b0}, 1'b1, '{ACT_SHIFT, 8'h00, 1'b1}},
    '{'{6'h01, 8'hF0, 1'b0}, 1'b0, '0},
    '{'{6'h00, 8'h3C, 1'b0}, 1'b0, '0},
    '{'{6'h3F, 8'hC3, 1'b1}, 1'b0, '0},
    '{'{6'h3F, 8'hAA, 1'b1}, 1'b0, '0},
    '{'{6'h3F, 8'h01, 1'b0}, 1'b1, '{ACT_SHIFT, 8'h00, 1'b1}},
    '{'{6'h00, 8'h02, 1'b0}, 1'b1, '{ACT_RIGHT, 8'h02, 1'b1}},
    '{'{6'h03, 8'h04, 1'b0}, 1'b1, '{ACT_SHIFT, 8'h00, 1'b1}},
    '{'{6'h00, 8'h08, 1'b0}, 1'b0, '0},
    '{'{6'h01, 8'h10, 1'b0}, 1'b0, '0},
    '{'{6'h3F, 8'h7F, 1'b1}, 1'b0, '0},
    '{'{6'h02, 8'h55, 1'b0}, 1'b1, '{ACT_SHIFT, 8'h00, 1'b1}},
    '{'{6'h00, 8'h66, 1'b0}, 1'b1, '{ACT_RIGHT, 8'h66, 1'b1}},
    '{'{6'h3F, 8'h77, 1'b1}, 1'b0, '0}
  };

  logic      clk;
  logic      rst;
  logic      tok_valid;
  logic      tok_stall;
  tok_item_t tok;
  logic      act_valid;
  logic      act_stall;
  act_item_t act;

  arc_eager_oracle_unit uut (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok),
    .act_valid (act_valid),
    .act_stall (act_stall),
    .act       (act)
  );

  // oracle model state
  logic [TOK_W-1:0]   parse_stack [MAXT];
  int                 parse_depth;
  int                 next_index;
  int                 assigned [MAXT];
  int                 gold_at [MAXT];
  logic [LABEL_W-1:0] label_at [MAXT];

  act_item_t token_actions [$];
  act_item_t pending_actions [$];
  int        tokens_sent;
  int        acts_seen;
  int        mismatches;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Append one action to the list for the current token.
  function automatic void add_action(input action_t a, input logic [LABEL_W-1:0] lab);
    act_item_t entry;
    entry.action     = a;
    entry.arc_label  = lab;
    entry.end_of_run = 1'b0;
    token_actions    = {token_actions, entry};
  endfunction

  // Work out the actions one token causes and advance the model.
  function automatic void derive_actions(input tok_item_t it);
    int         beta;
    int         g;
    int         s;
    int         t;
    logic       last;
    logic       done;
    logic       popped;
    logic [5:0] hv;
    token_actions.delete();
    if (next_index <= 0 || next_index >= MAXT) begin
      next_index  = 0;
      parse_depth = 0;
      foreach (assigned[i]) assigned[i] = NO_HEAD;
    end
    beta = next_index;
    hv = it.gold_head;
    g = hv[5] ? NO_HEAD : int'(hv);
    gold_at[beta]  = g;
    label_at[beta] = it.gold_label;
    last = it.is_last || (beta >= MAXT - 1);
    done = 1'b0;
    while (!done) begin
      popped = 1'b0;
      if (parse_depth > 0) begin
        s = parse_stack[parse_depth-1];
        t = s;
        // follow assigned heads down to the chain root
        for (int k = 0; k < MAXT && assigned[t] >= 0; k++) t = assigned[t];
        if (gold_at[t] == beta) begin
          if (t == s) begin
            add_action(ACT_LEFT, label_at[t]);
            assigned[t] = beta;
          end else begin
            add_action(ACT_REDUCE, 8'h00);
          end
          parse_depth--;
          popped = 1'b1;
        end
      end
      if (!popped) begin
        if (g < 0 || g > beta || parse_depth == 0) begin
          add_action(ACT_SHIFT, 8'h00);
          if (parse_depth < MAXT) parse_stack[parse_depth++] = beta[TOK_W-1:0];
          done = 1'b1;
        end else if (g == parse_stack[parse_depth-1]) begin
          add_action(ACT_RIGHT, label_at[beta]);
          assigned[beta] = g;
          if (parse_depth < MAXT) parse_stack[parse_depth++] = beta[TOK_W-1:0];
          done = 1'b1;
        end else begin
          add_action(ACT_REDUCE, 8'h00);
          parse_depth--;
        end
      end
    end
    next_index = beta + 1;
    if (last) begin
      while (parse_depth > 0) begin
        add_action(ACT_REDUCE, 8'h00);
        parse_depth--;
      end
      next_index = 0;
    end
    token_actions[token_actions.size()-1].end_of_run = 1'b1;
  endfunction

  function automatic void flag_mismatch(input string what, input act_item_t want,
                                        input act_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"MISMATCH %s at %0t: expected action=%0d label=%02h end=%0b,",
                " got action=%0d label=%02h end=%0b"},
               what, $time, want.action, want.arc_label, want.end_of_run,
               got.action, got.arc_label, got.end_of_run);
  endfunction

  // Offer one token from a falling edge; return on the falling edge after
  // the transaction.
  task automatic send_token(input tok_item_t it, input logic known, input act_item_t want);
    logic gaps_on;
    gaps_on = !(tokens_sent >= 120 && tokens_sent < 180);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      tok_valid <= 1'b0;
      tok       <= tok_item_t'($bits(tok_item_t)'($urandom));
      @(negedge clk);
    end
    tok_valid <= 1'b1;
    tok       <= it;
    @(posedge clk);
    while (tok_stall) @(posedge clk);
    derive_actions(it);
    if (known) pending_actions = {pending_actions, want};
    else pending_actions = {pending_actions, token_actions};
    tokens_sent++;
    @(negedge clk);
  endtask

  // Heads fall within +/- spread of the token, with some roots.
  task automatic send_sentence(input int n, input int spread, input logic closed);
    tok_item_t it;
    int        h;
    int        lo;
    int        hi;
    for (int i = 0; i < n; i++) begin
      if (n == 1 || $urandom_range(99) < 12) begin
        h = -$urandom_range(32, 1);
      end else begin
        lo = (i - spread < 0) ? 0 : i - spread;
        hi = (i + spread > n - 1) ? n - 1 : i + spread;
        do h = $urandom_range(hi, lo); while (h == i);
      end
      it.gold_head  = 6'(h);
      it.gold_label = 8'($urandom);
      it.is_last    = closed && (i == n - 1);
      send_token(it, 1'b0, '0);
    end
  endtask

  initial begin : token_side
    int        roll;
    tok_item_t noise;
    rst         = 1'b1;
    tok_valid   = 1'b0;
    tok         = '0;
    tokens_sent = 0;
    parse_depth = 0;
    next_index  = 0;
    foreach (assigned[i]) begin
      assigned[i] = NO_HEAD;
      gold_at[i]  = 0;
      label_at[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script_rows[r])
      send_token(script_rows[r].item, script_rows[r].known, script_rows[r].want);

    // overlong chain: token 31 closes the sentence, token 32 opens a new one
    for (int i = 0; i < MAXT + 1; i++)
      send_token('{6'(i - 1), 8'($urandom), 1'b0}, 1'b0, '0);

    while (tokens_sent < RAND_TOKS) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_sentence($urandom_range(8, 1), $urandom_range(3, 1), 1'b1);
      end else if (roll < 80) begin
        send_sentence($urandom_range(MAXT, 16), $urandom_range(6, 1), 1'b1);
      end else if (roll < 88) begin
        send_sentence($urandom_range(8, 1), $urandom_range(3, 1), 1'b0);
      end else if (roll < 94) begin
        send_sentence($urandom_range(MAXT + 4, MAXT), $urandom_range(4, 1), 1'b0);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          noise.gold_head  = 6'($urandom);
          noise.gold_label = 8'($urandom);
          noise.is_last    = ($urandom_range(99) < 15);
          send_token(noise, 1'b0, '0);
        end
      end
    end
    tok_valid <= 1'b0;

    while (pending_actions.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_actions.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : act_side
    logic held;
    held      = 1'b0;
    act_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && acts_seen >= 300) begin
        // hold off long enough for the unit to back up into its input
        held = 1'b1;
        act_stall <= 1'b1;
        repeat (250) @(negedge clk);
      end
      if (acts_seen >= 100 && acts_seen < 200)
        act_stall <= 1'b0;
      else
        act_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    acts_seen  = 0;
    mismatches = 0;
  end

  always @(posedge clk) begin
    act_item_t want;
    if (!rst && act_valid && !act_stall) begin
      acts_seen++;
      if (pending_actions.size() == 0) begin
        flag_mismatch("unexpected action", '0, act);
      end else begin
        want = pending_actions.pop_front();
        if (act.action !== want.action || act.arc_label !== want.arc_label ||
            act.end_of_run !== want.end_of_run)
          flag_mismatch("action", want, act);
      end
    end
  end

endmodule
